// File: hw/rtl/mtas_pkg.sv
// shared types and constants for the median then average smoother
package mtas_pkg;

    localparam int DATA_W          = 32;
    localparam int MEDIAN_LEN_DEF  = 5;
    localparam int AVERAGE_LEN_DEF = 6;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] smooth_x;
        logic signed [DATA_W-1:0] smooth_y;
    } t_out;

    typedef struct packed {
        logic load;
        logic med_step;
        logic med_push;
        logic sum_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

endpackage

// File: hw/rtl/mtas_ctrl.sv
// controller state machine with window fill counts and output valid
module mtas_ctrl import mtas_pkg::*; #(
    parameter int MEDIAN_LEN  = MEDIAN_LEN_DEF,
    parameter int AVERAGE_LEN = AVERAGE_LEN_DEF,
    localparam int MFILL_W    = $clog2(MEDIAN_LEN + 1),
    localparam int AFILL_W    = $clog2(AVERAGE_LEN + 1),
    localparam int SUM_W      = DATA_W + $clog2(AVERAGE_LEN),
    localparam int STEP_W     = $clog2(SUM_W)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_cmd               o_cmd,
    output logic [STEP_W-1:0]  o_step,
    output logic [MFILL_W-1:0] o_raw_fill,
    output logic [AFILL_W-1:0] o_med_fill
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MED   = 3'd1;
    localparam logic [2:0] S_MPUSH = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_DIVLD = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [MFILL_W-1:0] r_raw_fill, n_raw_fill;
    logic [AFILL_W-1:0] r_med_fill, n_med_fill;
    logic               r_out_valid, n_out_valid;
    logic               w_accept;
    logic               w_out_free;
    logic               w_med_last;
    logic               w_sum_last;
    logic               w_div_last;
    t_cmd               w_cmd;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_med_last = (({1'b0, r_step} + 1'b1) == (STEP_W + 1)'(r_raw_fill));
    assign w_sum_last = (({1'b0, r_step} + 1'b1) == (STEP_W + 1)'(r_med_fill));
    assign w_div_last = (r_step == STEP_W'(SUM_W - 1));

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_raw_fill = r_raw_fill;
        n_med_fill = r_med_fill;
        w_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.load = 1'b1;
                    if (r_raw_fill != MFILL_W'(MEDIAN_LEN)) begin
                        n_raw_fill = r_raw_fill + 1'b1;
                    end
                    n_step  = '0;
                    n_state = S_MED;
                end
            end
            S_MED: begin
                w_cmd.med_step = 1'b1;
                if (w_med_last) begin
                    n_state = S_MPUSH;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_MPUSH: begin
                w_cmd.med_push = 1'b1;
                if (r_med_fill != AFILL_W'(AVERAGE_LEN)) begin
                    n_med_fill = r_med_fill + 1'b1;
                end
                n_step  = '0;
                n_state = S_SUM;
            end
            S_SUM: begin
                w_cmd.sum_step = 1'b1;
                if (w_sum_last) begin
                    n_state = S_DIVLD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DIVLD: begin
                w_cmd.div_load = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (w_div_last) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_raw_fill  <= '0;
            r_med_fill  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_raw_fill  <= n_raw_fill;
            r_med_fill  <= n_med_fill;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_step      = r_step;
    assign o_raw_fill  = r_raw_fill;
    assign o_med_fill  = r_med_fill;
    assign o_out_valid = r_out_valid;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_raw_fill <= MFILL_W'(MEDIAN_LEN)) && (r_med_fill <= AFILL_W'(AVERAGE_LEN)))
        else $error("window fill count out of range");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command at once");

    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> (r_raw_fill != '0) && (r_state == S_MED))
        else $error("transaction taken without raw window entry");

    a_med_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MPUSH) |=> $stable(r_med_fill))
        else $error("median fill changed outside push");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_DIVLD) |-> (r_med_fill != '0))
        else $error("divide by empty median window");

endmodule

// File: hw/rtl/mtas_dp.sv
// datapath: raw windows, rank median, median windows, summing and serial divide
module mtas_dp import mtas_pkg::*; #(
    parameter int MEDIAN_LEN  = MEDIAN_LEN_DEF,
    parameter int AVERAGE_LEN = AVERAGE_LEN_DEF,
    localparam int MFILL_W    = $clog2(MEDIAN_LEN + 1),
    localparam int AFILL_W    = $clog2(AVERAGE_LEN + 1),
    localparam int SUM_W      = DATA_W + $clog2(AVERAGE_LEN),
    localparam int STEP_W     = $clog2(SUM_W)
) (
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    input  logic [STEP_W-1:0]  i_step,
    input  logic [MFILL_W-1:0] i_raw_fill,
    input  logic [AFILL_W-1:0] i_med_fill,
    input  t_in                i_in,
    output t_out               o_out
);

    localparam int MIDX_W = (MEDIAN_LEN > 1) ? $clog2(MEDIAN_LEN) : 1;
    localparam int AIDX_W = (AVERAGE_LEN > 1) ? $clog2(AVERAGE_LEN) : 1;

    logic signed [DATA_W-1:0] w_new [2];
    logic signed [DATA_W-1:0] w_res [2];

    assign w_new[0] = i_in.pos_x;
    assign w_new[1] = i_in.pos_y;

    for (genvar c = 0; c < 2; c++) begin : g_lane
        logic signed [DATA_W-1:0] r_raw [MEDIAN_LEN];
        logic signed [DATA_W-1:0] r_mwin [AVERAGE_LEN];
        logic signed [DATA_W-1:0] r_median;
        logic signed [SUM_W-1:0]  r_acc;
        logic [AFILL_W-1:0]       r_rem;
        logic [SUM_W-1:0]         r_quo;
        logic                     r_neg;
        logic signed [DATA_W-1:0] r_res;
        logic signed [DATA_W-1:0] w_cand;
        logic [MFILL_W-1:0]       w_rank;
        logic [AFILL_W:0]         w_trial;
        logic                     w_qbit;

        assign w_cand = r_raw[i_step[MIDX_W-1:0]];

        // position of the candidate in the sorted window, ties broken by age
        always_comb begin
            w_rank = '0;
            for (int j = 0; j < MEDIAN_LEN; j++) begin
                if ((MFILL_W'(j) < i_raw_fill) &&
                    ((r_raw[j] < w_cand) ||
                     ((r_raw[j] == w_cand) && (STEP_W'(j) < i_step)))) begin
                    w_rank = w_rank + 1'b1;
                end
            end
        end

        assign w_trial = {r_rem, r_quo[SUM_W-1]};
        assign w_qbit  = (w_trial >= {1'b0, i_med_fill});

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                if (i_raw_fill == MFILL_W'(MEDIAN_LEN)) begin
                    for (int j = 0; j < MEDIAN_LEN - 1; j++) begin
                        r_raw[j] <= r_raw[j + 1];
                    end
                    r_raw[MEDIAN_LEN - 1] <= w_new[c];
                end else begin
                    r_raw[i_raw_fill[MIDX_W-1:0]] <= w_new[c];
                end
            end
            if (i_cmd.med_step && (w_rank == (i_raw_fill >> 1))) begin
                r_median <= w_cand;
            end
            if (i_cmd.med_push) begin
                if (i_med_fill == AFILL_W'(AVERAGE_LEN)) begin
                    for (int j = 0; j < AVERAGE_LEN - 1; j++) begin
                        r_mwin[j] <= r_mwin[j + 1];
                    end
                    r_mwin[AVERAGE_LEN - 1] <= r_median;
                end else begin
                    r_mwin[i_med_fill[AIDX_W-1:0]] <= r_median;
                end
                r_acc <= '0;
            end
            if (i_cmd.sum_step) begin
                r_acc <= r_acc + SUM_W'(r_mwin[i_step[AIDX_W-1:0]]);
            end
            // restoring divide of the magnitude, one quotient bit per cycle
            if (i_cmd.div_load) begin
                r_neg <= r_acc[SUM_W-1];
                r_quo <= r_acc[SUM_W-1] ? $unsigned(-r_acc) : $unsigned(r_acc);
                r_rem <= '0;
            end
            if (i_cmd.div_step) begin
                if (w_qbit) begin
                    r_rem <= AFILL_W'(w_trial - {1'b0, i_med_fill});
                end else begin
                    r_rem <= w_trial[AFILL_W-1:0];
                end
                r_quo <= {r_quo[SUM_W-2:0], w_qbit};
            end
            if (i_cmd.out_load) begin
                r_res <= r_neg ? -$signed(r_quo[DATA_W-1:0]) : $signed(r_quo[DATA_W-1:0]);
            end
        end

        assign w_res[c] = r_res;
    end

    assign o_out.smooth_x = w_res[0];
    assign o_out.smooth_y = w_res[1];

endmodule

// File: hw/rtl/median_then_average_smoother_unit.sv
// top level of the median then moving average position smoother
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+--------------------------------
//  input    | i_in_valid   | o_in_stall   | i_in_data  (pos_x, pos_y)
//  output   | o_out_valid  | i_out_stall  | o_out_data (smooth_x, smooth_y)
//
//  one transaction at a time: the input stalls from acceptance until the result is loaded,
//  SUM_W = 32 + clog2(AVERAGE_LEN) is the width of the sum and of the quotient
//  the serial restoring divider divides the sum by the median fill count
//  synchronous active low reset empties both windows, no clearing pass
//  a finished result waits in the output register while the next item is taken
//  output stall only holds the last step of an item until the register frees
module median_then_average_smoother_unit import mtas_pkg::*; #(
    parameter int MEDIAN_LEN  = MEDIAN_LEN_DEF,
    parameter int AVERAGE_LEN = AVERAGE_LEN_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int MFILL_W = $clog2(MEDIAN_LEN + 1);
    localparam int AFILL_W = $clog2(AVERAGE_LEN + 1);
    localparam int SUM_W   = DATA_W + $clog2(AVERAGE_LEN);
    localparam int STEP_W  = $clog2(SUM_W);

    t_cmd               w_cmd;
    logic [STEP_W-1:0]  w_step;
    logic [MFILL_W-1:0] w_raw_fill;
    logic [AFILL_W-1:0] w_med_fill;

    mtas_ctrl #(
        .MEDIAN_LEN  (MEDIAN_LEN),
        .AVERAGE_LEN (AVERAGE_LEN)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .o_step      (w_step),
        .o_raw_fill  (w_raw_fill),
        .o_med_fill  (w_med_fill)
    );

    mtas_dp #(
        .MEDIAN_LEN  (MEDIAN_LEN),
        .AVERAGE_LEN (AVERAGE_LEN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_step     (w_step),
        .i_raw_fill (w_raw_fill),
        .i_med_fill (w_med_fill),
        .i_in       (i_in_data),
        .o_out      (o_out_data)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// testbench for the median then average smoother, with a scoreboard and random idling
module tb_top;
    import mtas_pkg::*;

    typedef logic signed [DATA_W-1:0] t_word;

    localparam int CLK_HALF   = 5;
    localparam int MAX_CYCLES = 200000;
    localparam int RANDOM_CNT = 550;
    localparam int HOLD_LEN   = 500;
    localparam int DRAIN_WAIT = 60;

    typedef enum int {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } t_idle_mode;

    class smoother_scoreboard;
        t_word raw_x[MEDIAN_LEN_DEF];
        t_word raw_y[MEDIAN_LEN_DEF];
        int    raw_cnt;
        t_word mid_x[AVERAGE_LEN_DEF];
        t_word mid_y[AVERAGE_LEN_DEF];
        int    mid_cnt;
        t_out  expected_q[$];
        int    errors;

        function new();
            foreach (raw_x[i]) begin
                raw_x[i] = '0;
                raw_y[i] = '0;
            end
            foreach (mid_x[i]) begin
                mid_x[i] = '0;
                mid_y[i] = '0;
            end
            raw_cnt = 0;
            mid_cnt = 0;
            errors  = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%0t: %s", $realtime, msg);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function t_word median_of(t_word win[MEDIAN_LEN_DEF], int cnt);
            t_word srt[MEDIAN_LEN_DEF];
            t_word v;
            int    j;
            for (int i = 0; i < cnt; i++) begin
                v = win[i];
                j = i;
                while (j > 0 && srt[j-1] > v) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = v;
            end
            return srt[cnt/2];
        endfunction

        function t_word mean_of(t_word win[AVERAGE_LEN_DEF], int cnt);
            longint acc;
            longint q;
            acc = 0;
            for (int i = 0; i < cnt; i++) begin
                acc += longint'(win[i]);
            end
            q = acc / longint'(cnt);
            return q[DATA_W-1:0];
        endfunction

        function void note_input(t_in d);
            t_out  e;
            t_word mx;
            t_word my;
            if (raw_cnt < MEDIAN_LEN_DEF) begin
                raw_x[raw_cnt] = d.pos_x;
                raw_y[raw_cnt] = d.pos_y;
                raw_cnt++;
            end else begin
                for (int i = 1; i < MEDIAN_LEN_DEF; i++) begin
                    raw_x[i-1] = raw_x[i];
                    raw_y[i-1] = raw_y[i];
                end
                raw_x[MEDIAN_LEN_DEF-1] = d.pos_x;
                raw_y[MEDIAN_LEN_DEF-1] = d.pos_y;
            end
            mx = median_of(raw_x, raw_cnt);
            my = median_of(raw_y, raw_cnt);
            if (mid_cnt < AVERAGE_LEN_DEF) begin
                mid_x[mid_cnt] = mx;
                mid_y[mid_cnt] = my;
                mid_cnt++;
            end else begin
                for (int i = 1; i < AVERAGE_LEN_DEF; i++) begin
                    mid_x[i-1] = mid_x[i];
                    mid_y[i-1] = mid_y[i];
                end
                mid_x[AVERAGE_LEN_DEF-1] = mx;
                mid_y[AVERAGE_LEN_DEF-1] = my;
            end
            e.smooth_x = mean_of(mid_x, mid_cnt);
            e.smooth_y = mean_of(mid_y, mid_cnt);
            expected_q.insert(expected_q.size(), e);
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected transaction x=%h y=%h",
                                 got.smooth_x, got.smooth_y));
                return;
            end
            e = expected_q[0];
            expected_q.delete(0);
            if (got.smooth_x !== e.smooth_x) begin
                report($sformatf("smooth_x mismatch: expected %h actual %h",
                                 e.smooth_x, got.smooth_x));
            end
            if (got.smooth_y !== e.smooth_y) begin
                report($sformatf("smooth_y mismatch: expected %h actual %h",
                                 e.smooth_y, got.smooth_y));
            end
        endfunction
    endclass

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic in_valid   = 1'b0;
    t_in  in_data    = '0;
    logic rx_stall   = 1'b0;
    logic hold_stall = 1'b0;
    logic out_stall;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    smoother_scoreboard sb = new();
    t_idle_mode idle_mode  = IDLE_FULL;
    int    items_sent      = 0;
    int    cycles          = 0;
    t_word traj_x          = '0;
    t_word traj_y          = '0;

    assign out_stall = rx_stall | hold_stall;

    median_then_average_smoother_unit #(
        .MEDIAN_LEN  (MEDIAN_LEN_DEF),
        .AVERAGE_LEN (AVERAGE_LEN_DEF)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int draw_gap();
        case (idle_mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            default:     return $urandom_range(0, 12);
        endcase
    endfunction

    function automatic t_word pick_extreme();
        case ($urandom_range(0, 5))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h7fff_fffe;
            3:       return 32'h8000_0001;
            4:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // mostly a drifting track with noise and outlier spikes
    function automatic t_in random_item();
        t_in d;
        int  sel;
        sel = $urandom_range(0, 9);
        if (sel <= 2) begin
            d.pos_x = $urandom;
            d.pos_y = $urandom;
        end else if (sel == 3) begin
            d.pos_x = pick_extreme();
            d.pos_y = pick_extreme();
        end else begin
            traj_x = traj_x + t_word'($urandom_range(0, 131072)) - 65536;
            traj_y = traj_y + t_word'($urandom_range(0, 131072)) - 65536;
            d.pos_x = traj_x + t_word'($urandom_range(0, 8191)) - 4096;
            d.pos_y = traj_y + t_word'($urandom_range(0, 8191)) - 4096;
            if ($urandom_range(0, 7) == 0) begin
                d.pos_x = d.pos_x + t_word'($urandom);
            end
            if ($urandom_range(0, 7) == 0) begin
                d.pos_y = d.pos_y - t_word'($urandom);
            end
        end
        return d;
    endfunction

    task automatic send_item(input t_in d);
        int g;
        g = draw_gap();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(d);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // result side with its own random stall
    initial begin : result_sink
        int w;
        forever begin
            w = draw_gap();
            if (w > 0) begin
                rx_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                rx_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !out_stall));
            sb.check_result(o_out_data);
        end
    end

    // long hold-off on the result side so the block backs up
    initial begin : long_hold
        while (items_sent < 150) @(posedge i_clk);
        hold_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_stall <= 1'b0;
    end

    initial begin : stimulus
        t_word dir_x[22];
        t_word dir_y[22];
        t_in   d;
        dir_x = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'hffff_fffe,
                  32'hffff_ffff, 32'hffff_fffe, 32'h0001_0000, 32'hffff_0000,
                  32'h1234_5678, 32'hedcb_a987};
        dir_y = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                  32'h8000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0003,
                  32'hffff_fffd, 32'h0000_0002, 32'hfffe_8000, 32'h0001_8000,
                  32'haaaa_5555, 32'h5555_aaaa};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int n = 0; n < 22; n++) begin
            d.pos_x = dir_x[n];
            d.pos_y = dir_y[n];
            send_item(d);
        end
        drain_results();
        for (int n = 0; n < RANDOM_CNT; n++) begin
            if (n % 50 == 0) begin
                idle_mode = t_idle_mode'($urandom_range(0, 2));
            end
            if (n == RANDOM_CNT / 2) begin
                drain_results();
            end
            send_item(random_item());
        end
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d transactions never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: median_then_average_smoother_unit.f
hw/rtl/mtas_pkg.sv
hw/rtl/mtas_ctrl.sv
hw/rtl/mtas_dp.sv
hw/rtl/median_then_average_smoother_unit.sv
dv/tb_top.sv
